[hw/rtl/swm_pkg.sv]
// shared types and codes for the sliding window median unit
`timescale 1ns / 1ps

package swm_pkg;

  // broadcast from the top level to every cell of the sorted chain
  typedef struct packed {
    logic step;   // a sample transfer updates the chain this cycle
    logic fresh;  // start of sequence: held samples are ignored
    logic full;   // window full: the oldest sample leaves
    logic clear;  // window size written: chain is emptied
  } swm_ctrl_t;

  localparam int unsigned WinSizeBits = 7;
  localparam logic [WinSizeBits-1:0] WinSizeReset = 7'd3;

endpackage

[hw/rtl/swm_cell.sv]
// one cell of the sorted chain: value, age and valid flag of one held sample
`timescale 1ns / 1ps

module swm_cell import swm_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = 32,
  parameter int unsigned AGE_W       = 6
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  swm_ctrl_t                     ctrl_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic [AGE_W-1:0]              oldest_age_i,
  // from the lower neighbor
  input  logic                          rm_below_i,
  input  logic                          left_inq_i,
  input  logic signed [SAMPLE_BITS-1:0] left_lp_val_i,
  input  logic [AGE_W-1:0]              left_lp_age_i,
  input  logic                          left_lp_vld_i,
  // from the upper neighbor
  input  logic signed [SAMPLE_BITS-1:0] right_val_i,
  input  logic [AGE_W-1:0]              right_age_i,
  input  logic                          right_vld_i,
  input  logic                          right_le_i,
  // to the neighbors
  output logic                          rm_below_o,
  output logic                          inq_o,
  output logic signed [SAMPLE_BITS-1:0] lp_val_o,
  output logic [AGE_W-1:0]              lp_age_o,
  output logic                          lp_vld_o,
  output logic signed [SAMPLE_BITS-1:0] val_o,
  output logic [AGE_W-1:0]              age_o,
  output logic                          vld_o,
  output logic                          le_o,
  output logic                          vld_q_o
);

  logic signed [SAMPLE_BITS-1:0] val_q, val_d;
  logic [AGE_W-1:0]              age_q, age_d;
  logic                          vld_q, vld_d;
  logic                          vld_eff;
  logic                          rm;
  logic                          below;
  logic                          lp_le;

  assign vld_eff = vld_q & ~ctrl_i.fresh;
  assign rm      = ctrl_i.full & vld_eff & (age_q == oldest_age_i);

  // removal point is at or below this cell once the flag is set
  assign rm_below_o = rm_below_i | rm;
  assign below      = ~rm_below_o;

  assign le_o  = vld_eff & ~(val_q > sample_i);
  assign val_o = val_q;
  assign age_o = age_q;
  assign vld_o = vld_eff;
  assign vld_q_o = vld_q;

  // contents after removal of the oldest sample
  assign lp_val_o = below ? val_q   : right_val_i;
  assign lp_age_o = below ? age_q   : right_age_i;
  assign lp_vld_o = below ? vld_eff : right_vld_i;
  assign lp_le    = below ? le_o    : right_le_i;
  assign inq_o    = lp_le;

  always_comb begin
    val_d = val_q;
    age_d = age_q;
    vld_d = vld_q;
    if (ctrl_i.clear) begin
      vld_d = 1'b0;
    end else if (ctrl_i.step) begin
      if (inq_o) begin
        val_d = lp_val_o;
        age_d = lp_age_o + AGE_W'(1);
        vld_d = 1'b1;
      end else if (left_inq_i) begin
        val_d = sample_i;
        age_d = '0;
        vld_d = 1'b1;
      end else begin
        val_d = left_lp_val_i;
        age_d = left_lp_age_i + AGE_W'(1);
        vld_d = left_lp_vld_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    age_q <= age_d;
  end

endmodule

[hw/rtl/sliding_window_median_unit.sv]
// top level of the sliding window median unit: control, cell chain, median output
//
// channel | direction | handshake             | payload
// in      | input     | in_valid_i/in_stall_o | sample_i, start_of_sequence_i
// out     | output    | out_valid_o/out_stall_i | median_o
// cfg     | input     | cfg_valid_i/cfg_ready_o | window_size_i
//
// one sample per cycle while in_stall_o is low; each cell compares and shifts in the cycle of the transfer
// the median is picked from the cell chain into the output register once that register can take it
// input stalls only while a median waits behind a stalled output register
// reset and a window size write empty the window; stored samples need no clearing
`timescale 1ns / 1ps

module sliding_window_median_unit import swm_pkg::*; #(
  parameter int unsigned WINDOW_MAX  = 64,
  parameter int unsigned SAMPLE_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic                          start_of_sequence_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [SAMPLE_BITS-1:0] median_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [WinSizeBits-1:0]        window_size_i
);

  localparam int unsigned CNT_W = $clog2(WINDOW_MAX + 1);
  localparam int unsigned AGE_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

  logic [WinSizeBits-1:0] win_q;
  logic [CNT_W-1:0]       fill_q, fill_d;
  logic [CNT_W-1:0]       k_eff;
  logic [CNT_W-1:0]       fill_next;
  logic [AGE_W-1:0]       oldest_age;
  logic [AGE_W-1:0]       mid;
  logic                   cfg_wr;
  logic                   accept;
  logic                   emit;
  logic                   pend_q, pend_d;
  logic                   load;
  logic                   out_valid_q;
  logic signed [SAMPLE_BITS-1:0] median_q;
  logic signed [SAMPLE_BITS-1:0] mid_val;
  swm_ctrl_t              ctrl;

  // chain wiring, one spare entry on each end
  logic                          rm_below [WINDOW_MAX+1];
  logic                          inq      [WINDOW_MAX+1];
  logic signed [SAMPLE_BITS-1:0] lp_val   [WINDOW_MAX+1];
  logic [AGE_W-1:0]              lp_age   [WINDOW_MAX+1];
  logic                          lp_vld   [WINDOW_MAX+1];
  logic signed [SAMPLE_BITS-1:0] c_val    [WINDOW_MAX+1];
  logic [AGE_W-1:0]              c_age    [WINDOW_MAX+1];
  logic                          c_vld    [WINDOW_MAX+1];
  logic                          c_le     [WINDOW_MAX+1];
  logic [WINDOW_MAX-1:0]         held;
  logic [WINDOW_MAX-1:0]         sel;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i & cfg_ready_o;

  always_comb begin
    if (win_q == '0) begin
      k_eff = CNT_W'(1);
    end else if (32'(win_q) > 32'(WINDOW_MAX)) begin
      k_eff = CNT_W'(WINDOW_MAX);
    end else begin
      k_eff = CNT_W'(win_q);
    end
  end

  assign oldest_age = AGE_W'(k_eff - CNT_W'(1));
  assign mid        = AGE_W'((k_eff - CNT_W'(1)) >> 1);

  assign in_stall_o = pend_q & out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  assign ctrl.step  = accept;
  assign ctrl.fresh = start_of_sequence_i;
  assign ctrl.full  = (fill_q == k_eff) & ~start_of_sequence_i;
  assign ctrl.clear = cfg_wr;

  always_comb begin
    if (start_of_sequence_i) begin
      fill_next = CNT_W'(1);
    end else if (ctrl.full) begin
      fill_next = k_eff;
    end else begin
      fill_next = fill_q + CNT_W'(1);
    end
  end

  assign emit = (fill_next == k_eff);

  always_comb begin
    fill_d = fill_q;
    if (cfg_wr) begin
      fill_d = '0;
    end else if (accept) begin
      fill_d = fill_next;
    end
  end

  // cell chain
  assign rm_below[0]   = 1'b0;
  assign inq[0]        = 1'b1;
  assign lp_val[0]     = '0;
  assign lp_age[0]     = '0;
  assign lp_vld[0]     = 1'b0;
  assign c_val[WINDOW_MAX] = '0;
  assign c_age[WINDOW_MAX] = '0;
  assign c_vld[WINDOW_MAX] = 1'b0;
  assign c_le[WINDOW_MAX]  = 1'b0;

  for (genvar j = 0; j < WINDOW_MAX; j++) begin : g_cell
    swm_cell #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .AGE_W      (AGE_W)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .sample_i      (sample_i),
      .oldest_age_i  (oldest_age),
      .rm_below_i    (rm_below[j]),
      .left_inq_i    (inq[j]),
      .left_lp_val_i (lp_val[j]),
      .left_lp_age_i (lp_age[j]),
      .left_lp_vld_i (lp_vld[j]),
      .right_val_i   (c_val[j+1]),
      .right_age_i   (c_age[j+1]),
      .right_vld_i   (c_vld[j+1]),
      .right_le_i    (c_le[j+1]),
      .rm_below_o    (rm_below[j+1]),
      .inq_o         (inq[j+1]),
      .lp_val_o      (lp_val[j+1]),
      .lp_age_o      (lp_age[j+1]),
      .lp_vld_o      (lp_vld[j+1]),
      .val_o         (c_val[j]),
      .age_o         (c_age[j]),
      .vld_o         (c_vld[j]),
      .le_o          (c_le[j]),
      .vld_q_o       (held[j])
    );
    assign sel[j] = (AGE_W'(j) == mid);
  end

  // median pick: and-or over the cells
  always_comb begin
    mid_val = '0;
    for (int j = 0; j < WINDOW_MAX; j++) begin
      mid_val = mid_val | (c_val[j] & {SAMPLE_BITS{sel[j]}});
    end
  end

  assign load = pend_q & (~out_valid_q | ~out_stall_i);

  always_comb begin
    pend_d = pend_q;
    if (accept) begin
      pend_d = emit;
    end else if (load) begin
      pend_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q       <= WinSizeReset;
      fill_q      <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_wr) begin
        win_q <= window_size_i;
      end
      fill_q <= fill_d;
      pend_q <= pend_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      median_q <= mid_val;
    end
  end

  assign out_valid_o = out_valid_q;
  assign median_o    = median_q;

  // checks
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= k_eff)
    else $error("fill count above window size");

  a_held_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(held) == 32'(fill_q))
    else $error("valid cells do not match fill count");

  a_emit_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && emit && !cfg_wr |=> pend_q)
    else $error("median of a full window not queued");

  a_load_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> out_valid_q)
    else $error("queued median not moved to output");

endmodule

[tb/tb_sliding_window_median_unit.sv]
// testbench for the sliding window median unit: directed and random sample streams checked
`timescale 1ns / 1ps

module tb_sliding_window_median_unit;
  import swm_pkg::*;

  localparam int unsigned WindowMax  = 64;
  localparam int unsigned SampleBits = 32;
  localparam int unsigned IdleLimit  = 1000;
  localparam int unsigned DrainWait  = 4;

  typedef logic signed [SampleBits-1:0] sample_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   in_valid_i;
  logic                   in_stall_o;
  sample_t                sample_i;
  logic                   start_of_sequence_i;
  logic                   out_valid_o;
  logic                   out_stall_i;
  sample_t                median_o;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [WinSizeBits-1:0] window_size_i;

  sliding_window_median_unit #(
    .WINDOW_MAX (WindowMax),
    .SAMPLE_BITS(SampleBits)
  ) u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .sample_i           (sample_i),
    .start_of_sequence_i(start_of_sequence_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .median_o           (median_o),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .window_size_i      (window_size_i)
  );

  // window model
  logic [WinSizeBits-1:0] win_size;
  sample_t                sorted_win [WindowMax];
  sample_t                arrival_win[WindowMax];
  int unsigned            oldest_pos;
  int unsigned            held_count;
  sample_t                pending_medians[$];
  sample_t                next_median;
  int                     err_count;
  int unsigned            idle_cycles;
  int unsigned            stall_mode_left;
  int unsigned            stall_mode;
  int unsigned            stall_run;

  initial begin
    clk_i = 1'b0;
  end

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic int unsigned live_size();
    int unsigned k;
    k = 32'(win_size);
    if (k < 1) k = 1;
    if (k > WindowMax) k = WindowMax;
    return k;
  endfunction

  function automatic void sorted_place(input int unsigned count, input sample_t v);
    int unsigned i;
    i = count;
    while (i > 0 && sorted_win[i-1] > v) begin
      sorted_win[i] = sorted_win[i-1];
      i--;
    end
    sorted_win[i] = v;
  endfunction

  function automatic void sorted_drop(input int unsigned count, input sample_t v);
    int unsigned i;
    i = 0;
    while (i < count && sorted_win[i] != v) i++;
    if (i < count) begin
      while (i + 1 < count) begin
        sorted_win[i] = sorted_win[i+1];
        i++;
      end
    end
  endfunction

  // advance the window by one sample and queue the median when the window is full
  function automatic void window_push(input sample_t x, input logic fresh);
    int unsigned k;
    sample_t     leaving;
    k = live_size();
    if (fresh) begin
      held_count = 0;
      oldest_pos = 0;
    end
    if (held_count > k) held_count = k;
    if (oldest_pos >= k) oldest_pos = 0;
    if (held_count < k) begin
      sorted_place(held_count, x);
      arrival_win[(oldest_pos + held_count) % k] = x;
      held_count++;
    end else begin
      leaving = arrival_win[oldest_pos];
      sorted_drop(k, leaving);
      sorted_place(k - 1, x);
      arrival_win[oldest_pos] = x;
      oldest_pos = (oldest_pos + 1) % k;
    end
    if (held_count == k) pending_medians.push_back(sorted_win[(k - 1) / 2]);
  endfunction

  function automatic sample_t rand_sample();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) return sample_t'($urandom);
    if (pick < 8) return sample_t'($signed($urandom_range(0, 8)) - 4);
    case ($urandom_range(0, 3))
      0: return {1'b1, {(SampleBits-1){1'b0}}};
      1: return {1'b0, {(SampleBits-1){1'b1}}};
      2: return '0;
      default: return '1;
    endcase
  endfunction

  // one sample transfer; returns at the edge where it is taken
  task automatic send(input sample_t x, input logic fresh);
    in_valid_i          <= 1'b1;
    sample_i            <= x;
    start_of_sequence_i <= fresh;
    do @(posedge clk_i); while (in_stall_o);
    window_push(x, fresh);
  endtask

  task automatic end_burst();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_window(input logic [WinSizeBits-1:0] size);
    while (pending_medians.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    cfg_valid_i   <= 1'b1;
    window_size_i <= size;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    win_size   = size;
    held_count = 0;
    oldest_pos = 0;
  endtask

  task automatic stream(input int count, input bit gaps);
    int burst;
    int gap;
    while (count > 0) begin
      burst = $urandom_range(1, 24);
      while (burst > 0 && count > 0) begin
        send(rand_sample(), $urandom_range(0, 49) == 0);
        burst--;
        count--;
      end
      if (gaps) begin
        gap = $urandom_range(0, 8);
        if (gap > 0) begin
          in_valid_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
    end
    end_burst();
  endtask

  // reset size of three, extremes and repeated values
  task automatic test_default_window();
    send({1'b1, {(SampleBits-1){1'b0}}}, 1'b0);
    send({1'b0, {(SampleBits-1){1'b1}}}, 1'b0);
    send('0, 1'b0);
    send('1, 1'b0);
    send(sample_t'(5), 1'b0);
    send(sample_t'(5), 1'b0);
    send(sample_t'(5), 1'b0);
    send({1'b1, {(SampleBits-1){1'b0}}}, 1'b0);
    end_burst();
  endtask

  // start flag on a full window, a partial window and back to back
  task automatic test_start_flag();
    send(sample_t'(7), 1'b1);
    send(sample_t'(-3), 1'b0);
    send(sample_t'(9), 1'b1);
    send(sample_t'(1), 1'b1);
    send(sample_t'(2), 1'b0);
    send(sample_t'(-8), 1'b0);
    send(sample_t'(4), 1'b0);
    end_burst();
  endtask

  // size zero acts as one, then the smallest real sizes
  task automatic test_small_sizes();
    set_window('0);
    send(sample_t'(11), 1'b0);
    send({1'b1, {(SampleBits-1){1'b0}}}, 1'b0);
    send(sample_t'(-1), 1'b1);
    end_burst();
    set_window(WinSizeBits'(1));
    send(sample_t'(3), 1'b0);
    send(sample_t'(-3), 1'b0);
    end_burst();
    set_window(WinSizeBits'(2));
    send(sample_t'(6), 1'b0);
    send(sample_t'(2), 1'b0);
    send(sample_t'(2), 1'b0);
    send({1'b0, {(SampleBits-1){1'b1}}}, 1'b0);
    end_burst();
  endtask

  // random streams over fixed extremes and random sizes
  task automatic test_random_stream();
    logic [WinSizeBits-1:0] sizes[6];
    int                     counts[6];
    int                     p;
    sizes  = '{WinSizeBits'(4), WinSizeBits'(64), WinSizeBits'(1), '1, WinSizeBits'(2), '0};
    counts = '{140, 260, 140, 260, 140, 60};
    for (p = 0; p < 6; p++) begin
      set_window(sizes[p]);
      stream(counts[p], p[0]);
    end
    for (p = 0; p < 5; p++) begin
      set_window(WinSizeBits'($urandom_range(3, 16)));
      stream(140, p != 2);
    end
  endtask

  // output stall pattern: random stretches of none, light and heavy stalling
  always @(posedge clk_i) begin
    if (stall_mode_left == 0) begin
      stall_mode      = $urandom_range(0, 2);
      stall_mode_left = $urandom_range(30, 200);
    end else begin
      stall_mode_left = stall_mode_left - 1;
    end
    if (stall_mode == 0 || stall_run >= 16) begin
      out_stall_i <= 1'b0;
      stall_run = 0;
    end else if ($urandom_range(0, 9) < (stall_mode == 1 ? 3 : 7)) begin
      out_stall_i <= 1'b1;
      stall_run = stall_run + 1;
    end else begin
      out_stall_i <= 1'b0;
      stall_run = 0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_medians.size() == 0) begin
        $error("median: no result expected, actual %0d", median_o);
        err_count++;
      end else begin
        next_median = pending_medians.pop_front();
        if (median_o !== next_median) begin
          $error("median: expected %0d, actual %0d", next_median, median_o);
          err_count++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)
        || (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_ni              <= 1'b0;
    in_valid_i          <= 1'b0;
    sample_i            <= '0;
    start_of_sequence_i <= 1'b0;
    out_stall_i         <= 1'b0;
    cfg_valid_i         <= 1'b0;
    window_size_i       <= '0;
    idle_cycles         <= 0;
    err_count       = 0;
    stall_mode      = 0;
    stall_mode_left = 0;
    stall_run       = 0;
    win_size        = WinSizeReset;
    held_count      = 0;
    oldest_pos      = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_default_window();
    test_start_flag();
    test_small_sizes();
    test_random_stream();

    while (pending_medians.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
